FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/swmm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window max/min package
// Shared defaults, register indexes, column codes, state and control types.
// ----------------------------------------------------------------------------
package swmm_pkg;

   localparam int MAX_WINDOW_DEFAULT   = 64;
   localparam int SAMPLE_WIDTH_DEFAULT = 32;

   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_COLUMN    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_COLUMN    = 2'd2;

   localparam int WINDOW_LENGTH_RESET = 9;

   typedef enum logic [1:0] {
      COL_HIGH  = 2'd0,
      COL_LOW   = 2'd1,
      COL_OPEN  = 2'd2,
      COL_CLOSE = 2'd3
   } column_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan;
      logic load;
   } swmm_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } swmm_status_type;

endpackage

FILE: src/sliding_window_max_min.sv
// ----------------------------------------------------------------------------
// Sliding window max/min
// Running highest and lowest selected price over the most recent bars.
//
//   Channel | Direction | Word contents
//   req     | in        | tdata: high, low, open, close; tuser: restart
//   rsp     | out       | tdata: window max, window min, samples used
//   csr     | in        | write enable, register index, write data
//
// An item takes one ring read per older sample, none when one sample is used,
// through the single read port of each ring, then the wait for the registered
// read data, a done check and the result load.
// Synchronous reset clears the series and the result and resets the registers.
// A result that waits on rsp does not block the next accept; the block stalls
// only when a finished result finds the output register still full.
// ----------------------------------------------------------------------------
module sliding_window_max_min #(
   parameter int MAX_WINDOW   = swmm_pkg::MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH  = $clog2(MAX_WINDOW + 1),
   parameter int REQ_WIDTH    = ((4 * SAMPLE_WIDTH + 7) / 8) * 8,
   parameter int RSP_WIDTH    = ((2 * SAMPLE_WIDTH + COUNT_WIDTH + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [swmm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COUNT_WIDTH-1:0]               csr_write_data,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // price_high, price_low, price_open, price_close, zero fill
   input  logic [REQ_WIDTH-1:0]                 req_tdata,
   // restart
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // window_max, window_min, samples_used, zero fill
   output logic [RSP_WIDTH-1:0]                 rsp_tdata
);

   import swmm_pkg::*;

   swmm_cmd_type    cmd;
   swmm_status_type status;

   swmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swmm_datapath #(
      .MAX_WINDOW   (MAX_WINDOW),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH),
      .REQ_WIDTH    (REQ_WIDTH),
      .RSP_WIDTH    (RSP_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

endmodule

FILE: src/swmm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

FILE: src/swmm_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding window max/min controller
// Sequences accept, ring scan and result load for one word at a time.
// ----------------------------------------------------------------------------
module swmm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  swmm_pkg::swmm_status_type status,
   output swmm_pkg::swmm_cmd_type    cmd
);

   import swmm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_RESULT: begin
            cmd.load = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

FILE: src/swmm_datapath.sv
// ----------------------------------------------------------------------------
// Sliding window max/min datapath
// Registers, sample rings, scan comparator and the result register.
// ----------------------------------------------------------------------------
module swmm_datapath #(
   parameter int MAX_WINDOW   = swmm_pkg::MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH  = $clog2(MAX_WINDOW + 1),
   parameter int REQ_WIDTH    = ((4 * SAMPLE_WIDTH + 7) / 8) * 8,
   parameter int RSP_WIDTH    = ((2 * SAMPLE_WIDTH + COUNT_WIDTH + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swmm_pkg::swmm_cmd_type               cmd,
   output swmm_pkg::swmm_status_type            status,
   input  logic                                 csr_write_enable,
   input  logic [swmm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COUNT_WIDTH-1:0]               csr_write_data,
   input  logic [REQ_WIDTH-1:0]                 req_tdata,
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [RSP_WIDTH-1:0]                 rsp_tdata
);

   import swmm_pkg::*;

   localparam int SlotWidth = $clog2(MAX_WINDOW);
   localparam int WideWidth = COUNT_WIDTH + 1;

   logic [COUNT_WIDTH-1:0]  window_length_ff;
   column_type              max_column_ff;
   column_type              min_column_ff;

   logic [SlotWidth-1:0]    write_slot_ff;
   logic [SlotWidth-1:0]    write_slot_in;
   logic [COUNT_WIDTH-1:0]  sample_count_ff;
   logic [COUNT_WIDTH-1:0]  sample_count_in;

   logic [SlotWidth-1:0]    cur_ff;
   logic [COUNT_WIDTH-1:0]  used_ff;
   logic [COUNT_WIDTH-1:0]  used_in;
   logic [COUNT_WIDTH-1:0]  k_ff;
   logic                    rd_pending_ff;
   logic [SAMPLE_WIDTH-1:0] best_hi_ff;
   logic [SAMPLE_WIDTH-1:0] best_lo_ff;

   logic                    rsp_valid_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_max_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_min_ff;
   logic [COUNT_WIDTH-1:0]  rsp_used_ff;

   logic [SAMPLE_WIDTH-1:0] price [4];
   logic [SAMPLE_WIDTH-1:0] max_sample;
   logic [SAMPLE_WIDTH-1:0] min_sample;
   logic [SlotWidth-1:0]    cur_slot;
   logic [COUNT_WIDTH-1:0]  next_slot_wide;
   logic [COUNT_WIDTH-1:0]  count_base;
   logic [COUNT_WIDTH-1:0]  win;
   logic                    rd_en;
   logic [WideWidth-1:0]    cur_wide;
   logic [WideWidth-1:0]    k_wide;
   logic [WideWidth-1:0]    rd_slot_wide;
   logic [SlotWidth-1:0]    rd_addr;
   logic [SAMPLE_WIDTH-1:0] max_rdata;
   logic [SAMPLE_WIDTH-1:0] min_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= COUNT_WIDTH'(WINDOW_LENGTH_RESET);
         max_column_ff    <= COL_HIGH;
         min_column_ff    <= COL_LOW;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: window_length_ff <= csr_write_data;
            CSR_MAX_COLUMN:    max_column_ff    <= column_type'(csr_write_data[1:0]);
            CSR_MIN_COLUMN:    min_column_ff    <= column_type'(csr_write_data[1:0]);
            default:           window_length_ff <= window_length_ff;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         price[i] = req_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
      end
   end

   assign max_sample = price[max_column_ff];
   assign min_sample = price[min_column_ff];

   always_comb begin
      cur_slot       = req_tuser ? '0 : write_slot_ff;
      next_slot_wide = COUNT_WIDTH'(cur_slot) + 1'b1;
      if (next_slot_wide == COUNT_WIDTH'(MAX_WINDOW)) begin
         write_slot_in = '0;
      end else begin
         write_slot_in = next_slot_wide[SlotWidth-1:0];
      end

      count_base = req_tuser ? '0 : sample_count_ff;
      if (count_base == COUNT_WIDTH'(MAX_WINDOW)) begin
         sample_count_in = count_base;
      end else begin
         sample_count_in = count_base + 1'b1;
      end

      if (window_length_ff == '0) begin
         win = COUNT_WIDTH'(1);
      end else if (window_length_ff > COUNT_WIDTH'(MAX_WINDOW)) begin
         win = COUNT_WIDTH'(MAX_WINDOW);
      end else begin
         win = window_length_ff;
      end
      used_in = (sample_count_in < win) ? sample_count_in : win;
   end

   assign rd_en    = cmd.scan && (k_ff < used_ff);
   assign cur_wide = WideWidth'(cur_ff);
   assign k_wide   = WideWidth'(k_ff);

   always_comb begin
      if (k_wide <= cur_wide) begin
         rd_slot_wide = cur_wide - k_wide;
      end else begin
         rd_slot_wide = cur_wide + WideWidth'(MAX_WINDOW) - k_wide;
      end
   end

   assign rd_addr = rd_slot_wide[SlotWidth-1:0];

   swmm_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_WINDOW)
   ) u_max_ring (
      .clock        (clock),
      .write_enable (cmd.accept),
      .write_addr   (cur_slot),
      .write_data   (max_sample),
      .read_enable  (rd_en),
      .read_addr    (rd_addr),
      .read_data    (max_rdata)
   );

   swmm_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_WINDOW)
   ) u_min_ring (
      .clock        (clock),
      .write_enable (cmd.accept),
      .write_addr   (cur_slot),
      .write_data   (min_sample),
      .read_enable  (rd_en),
      .read_addr    (rd_addr),
      .read_data    (min_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff   <= '0;
         sample_count_ff <= '0;
         rd_pending_ff   <= 1'b0;
      end else begin
         if (cmd.accept) begin
            write_slot_ff   <= write_slot_in;
            sample_count_ff <= sample_count_in;
         end
         rd_pending_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_ff     <= cur_slot;
         used_ff    <= used_in;
         k_ff       <= COUNT_WIDTH'(1);
         best_hi_ff <= max_sample;
         best_lo_ff <= min_sample;
      end else begin
         if (rd_en) begin
            k_ff <= k_ff + 1'b1;
         end
         if (rd_pending_ff) begin
            if ($signed(max_rdata) > $signed(best_hi_ff)) begin
               best_hi_ff <= max_rdata;
            end
            if ($signed(min_rdata) < $signed(best_lo_ff)) begin
               best_lo_ff <= min_rdata;
            end
         end
      end
   end

   assign status.scan_done = (k_ff >= used_ff) && !rd_pending_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_max_ff  <= best_hi_ff;
         rsp_min_ff  <= best_lo_ff;
         rsp_used_ff <= used_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_WIDTH'({rsp_used_ff, rsp_min_ff, rsp_max_ff});

endmodule

FILE: src/swmm_checker.sv
// ----------------------------------------------------------------------------
// Sliding window max/min checker
// Port-level assertions, attached to the top level by a bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swmm_checker #(
   parameter int MAX_WINDOW   = swmm_pkg::MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH  = $clog2(MAX_WINDOW + 1),
   parameter int REQ_WIDTH    = ((4 * SAMPLE_WIDTH + 7) / 8) * 8,
   parameter int RSP_WIDTH    = ((2 * SAMPLE_WIDTH + COUNT_WIDTH + 7) / 8) * 8
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 csr_write_enable,
   input logic [swmm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [COUNT_WIDTH-1:0]               csr_write_data,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [REQ_WIDTH-1:0]                 req_tdata,
   input logic                                 req_tuser,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [RSP_WIDTH-1:0]                 rsp_tdata
);

   logic [COUNT_WIDTH-1:0] rsp_used;
   logic                   req_accept;
   logic                   unused_inputs;

   assign rsp_used   = rsp_tdata[2*SAMPLE_WIDTH +: COUNT_WIDTH];
   assign req_accept = req_tvalid && req_tready;
   assign unused_inputs = csr_write_enable ^ (^csr_index) ^ (^csr_write_data)
                          ^ (^req_tdata) ^ req_tuser;

   `ASSERT_NEXT(rsp_valid_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "rsp_tvalid dropped before the word was taken")

   `ASSERT_SAME(rsp_used_range, clock, reset, rsp_tvalid,
      rsp_used != '0 && rsp_used <= COUNT_WIDTH'(MAX_WINDOW),
      "samples_used outside one to the window capacity")

   `ASSERT_NEXT(busy_after_accept, clock, reset, req_accept, !req_tready,
      "a second word was offered ready right after an accept")

   `ASSERT_NEXT_ALWAYS(reset_clears_rsp, clock, reset, !rsp_tvalid,
      "rsp_tvalid high right after reset")

endmodule

bind sliding_window_max_min swmm_checker #(
   .MAX_WINDOW   (MAX_WINDOW),
   .SAMPLE_WIDTH (SAMPLE_WIDTH),
   .COUNT_WIDTH  (COUNT_WIDTH),
   .REQ_WIDTH    (REQ_WIDTH),
   .RSP_WIDTH    (RSP_WIDTH)
) u_swmm_checker (.*);
